// ===== design/jsu_pkg.sv =====
package jsu_pkg;

   localparam int QDEPTH = 4;
   localparam int QAW    = $clog2(QDEPTH);

   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_N      = 8'h6E;
   localparam logic [7:0] CH_T      = 8'h74;
   localparam logic [7:0] CH_R      = 8'h72;
   localparam logic [7:0] CH_B      = 8'h62;
   localparam logic [7:0] CH_F      = 8'h66;
   localparam logic [7:0] CH_U      = 8'h75;

   localparam logic [7:0] CTL_LF = 8'h0A;
   localparam logic [7:0] CTL_HT = 8'h09;
   localparam logic [7:0] CTL_CR = 8'h0D;
   localparam logic [7:0] CTL_BS = 8'h08;
   localparam logic [7:0] CTL_FF = 8'h0C;

   localparam logic [7:0] LEAD_MIN  = 8'h80;
   localparam logic [7:0] LEAD_THREE = 8'hF0;
   localparam logic [7:0] LEAD_TWO  = 8'hE0;

   typedef enum logic [2:0] {
      MODE_NORMAL = 3'd0,
      MODE_ESCAPE = 3'd1,
      MODE_HEX    = 3'd2,
      MODE_CONT   = 3'd3,
      MODE_DONE   = 3'd4
   } mode_type;

   // one request's worth of results
   typedef struct packed {
      logic [1:0]      cnt;
      logic [2:0][7:0] bytes;
      logic            data_valid;
      logic            str_end;
      logic            unterm;
   } burst_type;

   typedef struct packed {
      logic       ok;
      logic [3:0] val;
   } hex_type;

   function automatic hex_type hex_digit(input logic [7:0] b);
      hex_type h;
      h.ok  = 1'b1;
      h.val = 4'd0;
      if (b >= 8'h30 && b <= 8'h39) begin
         h.val = 4'(b - 8'h30);
      end else if (b >= 8'h61 && b <= 8'h66) begin
         h.val = 4'(b - 8'h57);
      end else if (b >= 8'h41 && b <= 8'h46) begin
         h.val = 4'(b - 8'h37);
      end else begin
         h.ok = 1'b0;
      end
      return h;
   endfunction

   function automatic burst_type utf8_encode(input logic [15:0] cp);
      burst_type r;
      r = '0;
      r.data_valid = 1'b1;
      if (cp < 16'h0080) begin
         r.cnt      = 2'd1;
         r.bytes[0] = cp[7:0];
      end else if (cp < 16'h0800) begin
         r.cnt      = 2'd2;
         r.bytes[0] = 8'hC0 | {3'b000, cp[10:6]};
         r.bytes[1] = 8'h80 | {2'b00, cp[5:0]};
      end else begin
         r.cnt      = 2'd3;
         r.bytes[0] = 8'hE0 | {4'h0, cp[15:12]};
         r.bytes[1] = 8'h80 | {2'b00, cp[11:6]};
         r.bytes[2] = 8'h80 | {2'b00, cp[5:0]};
      end
      return r;
   endfunction

endpackage

// ===== design/json_string_unescaper.sv =====
// A request's results are registered in the queue when it is accepted and offered from its head.
// One request per cycle is accepted while the queue is not full and each yields at most
// one result; a request yielding two or three bytes (\u escapes) sends them out one by one,
// with a four-entry queue between decoder and output absorbing the bursts.
// Reset (synchronous, active high) empties the queue and puts the decoder in normal mode.
module json_string_unescaper import jsu_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_start_req,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_byte_valid,
   output logic       rsp_string_end,
   output logic       rsp_unterminated,
   output logic       rsp_last
);

   logic      accept, push, pop, empty, full;
   burst_type burst, head;

   assign req_stall = full;
   assign accept    = req_valid && !req_stall;

   jsu_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .in_byte   (req_in_byte),
      .start_req (req_start_req),
      .push      (push),
      .burst     (burst)
   );

   jsu_fifo u_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .wr_data (burst),
      .pop     (pop),
      .head    (head),
      .empty   (empty),
      .full    (full)
   );

   jsu_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head             (head),
      .empty            (empty),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_byte_valid   (rsp_byte_valid),
      .rsp_string_end   (rsp_string_end),
      .rsp_unterminated (rsp_unterminated),
      .rsp_last         (rsp_last)
   );

endmodule

// ===== design/jsu_front.sv =====
module jsu_front import jsu_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] in_byte,
   input  logic       start_req,
   output logic       push,
   output burst_type  burst
);

   mode_type    mode_ff, mode_in, mode_v;
   logic [1:0]  hex_ff, hex_in, hex_v;
   logic [15:0] cp_ff, cp_in, cp_v, cp_next;
   logic [1:0]  cont_ff, cont_in, cont_v;
   logic        is_end, unterm;
   hex_type     hx;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_NORMAL;
         hex_ff  <= '0;
         cp_ff   <= '0;
         cont_ff <= '0;
      end else if (accept) begin
         mode_ff <= mode_in;
         hex_ff  <= hex_in;
         cp_ff   <= cp_in;
         cont_ff <= cont_in;
      end
   end

   always_comb begin
      mode_v  = start_req ? MODE_NORMAL : mode_ff;
      hex_v   = start_req ? 2'd0 : hex_ff;
      cp_v    = start_req ? 16'd0 : cp_ff;
      cont_v  = start_req ? 2'd0 : cont_ff;
      mode_in = mode_v;
      hex_in  = hex_v;
      cp_in   = cp_v;
      cont_in = cont_v;
      burst   = '0;
      is_end  = 1'b0;
      unterm  = 1'b0;
      hx      = hex_digit(in_byte);
      cp_next = hx.ok ? {cp_v[11:0], hx.val} : cp_v;

      unique case (mode_v)
         MODE_NORMAL: begin
            if (in_byte == CH_NUL) begin
               is_end = 1'b1;
               unterm = 1'b1;
            end else if (in_byte == CH_QUOTE) begin
               is_end = 1'b1;
            end else if (in_byte == CH_BSLASH) begin
               mode_in = MODE_ESCAPE;
            end else begin
               burst.cnt        = 2'd1;
               burst.bytes[0]   = in_byte;
               burst.data_valid = 1'b1;
               if (in_byte >= LEAD_MIN) begin
                  mode_in = MODE_CONT;
                  if (in_byte >= LEAD_THREE) begin
                     cont_in = 2'd3;
                  end else if (in_byte >= LEAD_TWO) begin
                     cont_in = 2'd2;
                  end else begin
                     cont_in = 2'd1;
                  end
               end
            end
         end
         MODE_ESCAPE: begin
            mode_in          = MODE_NORMAL;
            burst.cnt        = 2'd1;
            burst.data_valid = 1'b1;
            unique case (in_byte)
               CH_NUL: begin
                  burst  = '0;
                  is_end = 1'b1;
                  unterm = 1'b1;
               end
               CH_N: burst.bytes[0] = CTL_LF;
               CH_T: burst.bytes[0] = CTL_HT;
               CH_R: burst.bytes[0] = CTL_CR;
               CH_B: burst.bytes[0] = CTL_BS;
               CH_F: burst.bytes[0] = CTL_FF;
               CH_U: begin
                  burst   = '0;
                  mode_in = MODE_HEX;
                  hex_in  = 2'd0;
                  cp_in   = 16'd0;
               end
               default: burst.bytes[0] = in_byte;
            endcase
         end
         MODE_HEX: begin
            if (in_byte == CH_NUL || in_byte == CH_QUOTE) begin
               burst  = utf8_encode(cp_v);
               is_end = 1'b1;
               unterm = (in_byte == CH_NUL);
            end else if (hex_v == 2'd3) begin
               burst   = utf8_encode(cp_next);
               hex_in  = 2'd0;
               cp_in   = 16'd0;
               mode_in = MODE_NORMAL;
            end else begin
               cp_in  = cp_next;
               hex_in = hex_v + 2'd1;
            end
         end
         MODE_CONT: begin
            if (in_byte == CH_NUL) begin
               is_end = 1'b1;
               unterm = 1'b1;
            end else begin
               burst.cnt        = 2'd1;
               burst.bytes[0]   = in_byte;
               burst.data_valid = 1'b1;
               if (cont_v > 2'd0) begin
                  cont_in = cont_v - 2'd1;
               end
               if (cont_v <= 2'd1) begin
                  mode_in = MODE_NORMAL;
               end
            end
         end
         MODE_DONE: ;
         default: ;
      endcase

      if (is_end) begin
         if (burst.cnt == 2'd0) begin
            burst.cnt        = 2'd1;
            burst.data_valid = 1'b0;
         end
         burst.str_end = 1'b1;
         burst.unterm  = unterm;
         mode_in       = MODE_DONE;
         hex_in        = 2'd0;
         cp_in         = 16'd0;
         cont_in       = 2'd0;
      end
      push = accept && (burst.cnt != 2'd0);
   end

endmodule

// ===== design/jsu_fifo.sv =====
module jsu_fifo import jsu_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  burst_type wr_data,
   input  logic      pop,
   output burst_type head,
   output logic      empty,
   output logic      full
);

   burst_type        mem_ff [QDEPTH];
   logic [QAW-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QAW:0]     count_ff, count_in;

   assign empty = (count_ff == '0);
   assign full  = (count_ff == (QAW+1)'(QDEPTH));
   assign head  = mem_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

// ===== design/jsu_back.sv =====
module jsu_back import jsu_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  burst_type  head,
   input  logic       empty,
   output logic       pop,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_byte_valid,
   output logic       rsp_string_end,
   output logic       rsp_unterminated,
   output logic       rsp_last
);

   logic [1:0] idx_ff, idx_in;
   logic       take;

   assign rsp_valid = !empty;
   assign take      = rsp_valid && !rsp_stall;
   assign rsp_last  = (idx_ff == head.cnt - 2'd1);
   assign pop       = take && rsp_last;

   always_comb begin
      case (idx_ff)
         2'd1:    rsp_out_byte = head.bytes[1];
         2'd2:    rsp_out_byte = head.bytes[2];
         default: rsp_out_byte = head.bytes[0];
      endcase
      rsp_byte_valid   = head.data_valid;
      rsp_string_end   = head.str_end && rsp_last;
      rsp_unterminated = head.unterm && rsp_last;
      idx_in           = idx_ff;
      if (pop) begin
         idx_in = 2'd0;
      end else if (take) begin
         idx_in = idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else begin
         idx_ff <= idx_in;
      end
   end

endmodule

// ===== design/jsu_checker.sv =====
module jsu_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_byte_valid,
   input logic       rsp_string_end,
   input logic       rsp_unterminated,
   input logic       rsp_last
);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response dropped while stalled");

   a_empty_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response offered right after reset");

   a_end_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_string_end |-> rsp_last)
      else $error("string end not on final response of request");

   a_unterm: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_unterminated |-> rsp_string_end)
      else $error("unterminated without string end");

   a_novalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_byte_valid |-> rsp_out_byte == 8'h00 && rsp_string_end)
      else $error("empty response not a clean end marker");

endmodule

bind json_string_unescaper jsu_checker u_jsu_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_out_byte     (rsp_out_byte),
   .rsp_byte_valid   (rsp_byte_valid),
   .rsp_string_end   (rsp_string_end),
   .rsp_unterminated (rsp_unterminated),
   .rsp_last         (rsp_last)
);
